### hdl/im2col_pkg.sv
// ----------------------------------------------------------------------------
// im2col_pkg
// Shared types and constants of the im2col address generator: register
// indexes and widths, field widths, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package im2col_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int DIM_REG_W   = 11;
    localparam int WIN_REG_W   = 5;
    localparam int STEP_W      = 5;
    localparam int PAD_W       = 4;
    localparam int MAX_STEP    = 16;

    localparam int ADDR_W = 30;
    localparam int KOFF_W = 4;
    localparam int IDX_W  = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNELS      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_WIDTH  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_HEIGHT = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_X        = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_Y        = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_PADDING       = 3'd7;

    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    typedef struct packed {
        logic div_start;
        logic div_sel;
        logic load_npx;
        logic load_npy;
        logic run;
    } im2col_cmd_t;

    typedef struct packed {
        logic div_done;
        logic cfg_hit;
    } im2col_status_t;

endpackage

### hdl/im2col_div.sv
// ----------------------------------------------------------------------------
// im2col_div
// Bit-serial restoring divider, one quotient bit per clock. Used to work out
// the patch count of each axis from the padded span and the stride.
// ----------------------------------------------------------------------------
module im2col_div
    import im2col_pkg::*;
#(
    parameter int NUM_W = 11
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [STEP_W-1:0] denom,
    output logic [NUM_W-1:0] quotient,
    output logic             done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [STEP_W-1:0] den_reg;
    logic [STEP_W-1:0] rem_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [STEP_W:0]   shifted;
    logic [STEP_W:0]   trial;

    assign shifted  = {rem_reg, quo_reg[NUM_W-1]};
    assign trial    = shifted - {1'b0, den_reg};
    assign quotient = quo_reg;
    assign done     = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            // a new start drops any division still running
            done_reg <= !start && busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= denom;
            rem_reg <= '0;
            quo_reg <= numer;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_reg <= trial[STEP_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[STEP_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

endmodule

### hdl/im2col_dp.sv
// ----------------------------------------------------------------------------
// im2col_dp
// Datapath: configuration registers, patch count setup, the nested element
// counters with running base offsets, and a two-stage address pipeline.
// ----------------------------------------------------------------------------
module im2col_dp
    import im2col_pkg::*;
#(
    parameter int MAX_DIM      = 1024,
    parameter int MAX_CHANNELS = 1024,
    parameter int MAX_WINDOW   = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  im2col_cmd_t            cmd,
    output im2col_status_t         status,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   restart,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [ADDR_W-1:0]      source_address,
    output logic                   is_padding,
    output logic [KOFF_W-1:0]      kernel_col,
    output logic [KOFF_W-1:0]      kernel_row,
    output logic [IDX_W-1:0]       channel_index,
    output logic [IDX_W-1:0]       patch_col,
    output logic [IDX_W-1:0]       patch_row,
    output logic                   last,
    output logic                   geometry_error
);

    localparam int DW  = $clog2(MAX_DIM + 1);
    localparam int PW  = $clog2(MAX_DIM);
    localparam int CCW = $clog2(MAX_CHANNELS + 1);
    localparam int CW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int WW  = $clog2(MAX_WINDOW + 1);
    localparam int KW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SW  = $clog2(MAX_DIM + 31);
    localparam int GW  = (SW > WW) ? SW : WW;
    localparam int XBW = $clog2(MAX_DIM * MAX_STEP);
    localparam int XW  = XBW + 2;
    localparam int RBW = $clog2(MAX_CHANNELS * MAX_DIM);
    localparam int AW  = RBW + DW;

    // configuration registers
    logic [DIM_REG_W-1:0] image_width_reg, image_height_reg, channels_reg;
    logic [WIN_REG_W-1:0] window_width_reg, window_height_reg;
    logic [WIN_REG_W-1:0] step_x_reg, step_y_reg;
    logic [CFG_DATA_W-1:0] padding_reg;

    // effective geometry
    logic [DW-1:0]     w_c, h_c;
    logic [CCW-1:0]    c_c;
    logic [WW-1:0]     ww_c, wh_c;
    logic [STEP_W-1:0] sx_c, sy_c;
    logic [PAD_W-1:0]  pl, pr, pt, pb;
    logic [GW-1:0]     span_x, span_y;
    logic              geo_now;

    logic [GW-1:0]     div_numer;
    logic [STEP_W-1:0] div_denom;
    logic [GW-1:0]     div_quotient;
    logic              div_done;
    logic [DW-1:0]     np_sat;

    logic [DW-1:0] npx_reg, npy_reg;
    logic          geo_reg;

    // element counters and running bases
    logic [PW-1:0]  pc_reg, pr_reg, pc_cur, pr_cur, pc_next, pr_next;
    logic [KW-1:0]  kc_reg, kr_reg, kc_cur, kr_cur, kc_next, kr_next;
    logic [CW-1:0]  ch_reg, ch_cur, ch_next;
    logic [XBW-1:0] xb_reg, yb_reg, xb_cur, yb_cur, xb_next, yb_next;
    logic [RBW-1:0] cb_reg, cb_cur, cb_next;
    logic           pc_wrap, pr_wrap, kc_wrap, kr_wrap, ch_wrap;

    logic signed [XW-1:0] x_s, y_s;
    logic                 pad_now;
    logic [RBW-1:0]       rowbase_now;

    logic accept, adv;

    // pipeline registers
    logic              s1_valid_reg, out_valid_reg;
    logic [RBW-1:0]    s1_rowbase_reg;
    logic [DW-1:0]     s1_x_reg;
    logic              s1_pad_reg, s1_last_reg, s1_geo_reg;
    logic [KOFF_W-1:0] s1_kc_reg, s1_kr_reg;
    logic [IDX_W-1:0]  s1_ch_reg, s1_pc_reg, s1_pr_reg;
    logic [ADDR_W-1:0] addr_out_reg;
    logic              pad_out_reg, last_out_reg, geo_out_reg;
    logic [KOFF_W-1:0] kc_out_reg, kr_out_reg;
    logic [IDX_W-1:0]  ch_out_reg, pc_out_reg, pr_out_reg;
    logic [AW-1:0]     addr_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= DIM_REG_W'(1);
            image_height_reg  <= DIM_REG_W'(1);
            channels_reg      <= DIM_REG_W'(1);
            window_width_reg  <= WIN_REG_W'(1);
            window_height_reg <= WIN_REG_W'(1);
            step_x_reg        <= WIN_REG_W'(1);
            step_y_reg        <= WIN_REG_W'(1);
            padding_reg       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[DIM_REG_W-1:0];
                REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[DIM_REG_W-1:0];
                REG_CHANNELS:      channels_reg      <= cfg_data[DIM_REG_W-1:0];
                REG_WINDOW_WIDTH:  window_width_reg  <= cfg_data[WIN_REG_W-1:0];
                REG_WINDOW_HEIGHT: window_height_reg <= cfg_data[WIN_REG_W-1:0];
                REG_STEP_X:        step_x_reg        <= cfg_data[WIN_REG_W-1:0];
                REG_STEP_Y:        step_y_reg        <= cfg_data[WIN_REG_W-1:0];
                REG_PADDING:       padding_reg       <= cfg_data;
            endcase
        end
    end

    // zero reads as one, large values saturate
    always_comb
    begin
        w_c = (image_width_reg == '0) ? DW'(1) :
              (32'(image_width_reg) > MAX_DIM) ? DW'(MAX_DIM) : DW'(image_width_reg);
        h_c = (image_height_reg == '0) ? DW'(1) :
              (32'(image_height_reg) > MAX_DIM) ? DW'(MAX_DIM) : DW'(image_height_reg);
        c_c = (channels_reg == '0) ? CCW'(1) :
              (32'(channels_reg) > MAX_CHANNELS) ? CCW'(MAX_CHANNELS) : CCW'(channels_reg);
        ww_c = (window_width_reg == '0) ? WW'(1) :
               (32'(window_width_reg) > MAX_WINDOW) ? WW'(MAX_WINDOW) : WW'(window_width_reg);
        wh_c = (window_height_reg == '0) ? WW'(1) :
               (32'(window_height_reg) > MAX_WINDOW) ? WW'(MAX_WINDOW) : WW'(window_height_reg);
        sx_c = (step_x_reg == '0) ? STEP_W'(1) :
               (32'(step_x_reg) > MAX_STEP) ? STEP_W'(MAX_STEP) : step_x_reg;
        sy_c = (step_y_reg == '0) ? STEP_W'(1) :
               (32'(step_y_reg) > MAX_STEP) ? STEP_W'(MAX_STEP) : step_y_reg;
        pl = padding_reg[3:0];
        pr = padding_reg[7:4];
        pt = padding_reg[11:8];
        pb = padding_reg[15:12];
        span_x  = GW'(w_c) + GW'(pl) + GW'(pr);
        span_y  = GW'(h_c) + GW'(pt) + GW'(pb);
        geo_now = (span_x < GW'(ww_c)) || (span_y < GW'(wh_c));
        div_numer = (cmd.div_sel == AXIS_Y) ? (span_y - GW'(wh_c)) : (span_x - GW'(ww_c));
        div_denom = (cmd.div_sel == AXIS_Y) ? sy_c : sx_c;
        np_sat = (32'(div_quotient) >= MAX_DIM) ? DW'(MAX_DIM) :
                 DW'(32'(div_quotient) + 32'd1);
    end

    im2col_div #(
        .NUM_W (GW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .numer    (div_numer),
        .denom    (div_denom),
        .quotient (div_quotient),
        .done     (div_done)
    );

    assign status.div_done = div_done;
    assign status.cfg_hit  = cfg_we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            npx_reg <= DW'(1);
            npy_reg <= DW'(1);
            geo_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_npx)
            begin
                npx_reg <= np_sat;
            end
            if (cmd.load_npy)
            begin
                npy_reg <= np_sat;
                geo_reg <= geo_now;
            end
        end
    end

    // handshake
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !(cmd.run && adv);
    assign accept   = in_valid && !in_stall;

    // counter advance, patch column fastest
    always_comb
    begin
        pc_cur = restart ? '0 : pc_reg;
        pr_cur = restart ? '0 : pr_reg;
        kc_cur = restart ? '0 : kc_reg;
        kr_cur = restart ? '0 : kr_reg;
        ch_cur = restart ? '0 : ch_reg;
        xb_cur = restart ? '0 : xb_reg;
        yb_cur = restart ? '0 : yb_reg;
        cb_cur = restart ? '0 : cb_reg;

        pc_wrap = (32'(pc_cur) + 32'd1) >= 32'(npx_reg);
        pr_wrap = (32'(pr_cur) + 32'd1) >= 32'(npy_reg);
        kc_wrap = (32'(kc_cur) + 32'd1) >= 32'(ww_c);
        kr_wrap = (32'(kr_cur) + 32'd1) >= 32'(wh_c);
        ch_wrap = (32'(ch_cur) + 32'd1) >= 32'(c_c);

        pc_next = pc_wrap ? '0 : pc_cur + PW'(1);
        xb_next = pc_wrap ? '0 : xb_cur + XBW'(sx_c);
        pr_next = pr_cur;
        yb_next = yb_cur;
        kc_next = kc_cur;
        kr_next = kr_cur;
        ch_next = ch_cur;
        cb_next = cb_cur;
        if (pc_wrap)
        begin
            pr_next = pr_wrap ? '0 : pr_cur + PW'(1);
            yb_next = pr_wrap ? '0 : yb_cur + XBW'(sy_c);
            if (pr_wrap)
            begin
                kc_next = kc_wrap ? '0 : kc_cur + KW'(1);
                if (kc_wrap)
                begin
                    kr_next = kr_wrap ? '0 : kr_cur + KW'(1);
                    if (kr_wrap)
                    begin
                        ch_next = ch_wrap ? '0 : ch_cur + CW'(1);
                        cb_next = ch_wrap ? '0 : cb_cur + RBW'(h_c);
                    end
                end
            end
        end

        x_s = $signed(XW'(xb_cur)) + $signed(XW'(kc_cur)) - $signed(XW'(pl));
        y_s = $signed(XW'(yb_cur)) + $signed(XW'(kr_cur)) - $signed(XW'(pt));
        pad_now = (x_s < 0) || (y_s < 0) ||
                  (x_s >= $signed(XW'(w_c))) || (y_s >= $signed(XW'(h_c)));
        rowbase_now = cb_cur + RBW'($unsigned(y_s));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0;
            pr_reg <= '0;
            kc_reg <= '0;
            kr_reg <= '0;
            ch_reg <= '0;
            xb_reg <= '0;
            yb_reg <= '0;
            cb_reg <= '0;
        end
        else if (cfg_we || (accept && geo_reg))
        begin
            pc_reg <= '0;
            pr_reg <= '0;
            kc_reg <= '0;
            kr_reg <= '0;
            ch_reg <= '0;
            xb_reg <= '0;
            yb_reg <= '0;
            cb_reg <= '0;
        end
        else if (accept)
        begin
            pc_reg <= pc_next;
            pr_reg <= pr_next;
            kc_reg <= kc_next;
            kr_reg <= kr_next;
            ch_reg <= ch_next;
            xb_reg <= xb_next;
            yb_reg <= yb_next;
            cb_reg <= cb_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= accept;
            out_valid_reg <= s1_valid_reg;
        end
    end

    // stage 1: position, padding test, row base
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (geo_reg)
            begin
                s1_rowbase_reg <= '0;
                s1_x_reg       <= '0;
                s1_pad_reg     <= 1'b0;
                s1_last_reg    <= 1'b1;
                s1_geo_reg     <= 1'b1;
                s1_kc_reg      <= '0;
                s1_kr_reg      <= '0;
                s1_ch_reg      <= '0;
                s1_pc_reg      <= '0;
                s1_pr_reg      <= '0;
            end
            else
            begin
                s1_rowbase_reg <= rowbase_now;
                s1_x_reg       <= DW'($unsigned(x_s));
                s1_pad_reg     <= pad_now;
                s1_last_reg    <= pc_wrap && pr_wrap && kc_wrap && kr_wrap && ch_wrap;
                s1_geo_reg     <= 1'b0;
                s1_kc_reg      <= KOFF_W'(kc_cur);
                s1_kr_reg      <= KOFF_W'(kr_cur);
                s1_ch_reg      <= IDX_W'(ch_cur);
                s1_pc_reg      <= IDX_W'(pc_cur);
                s1_pr_reg      <= IDX_W'(pr_cur);
            end
        end
    end

    // stage 2: (channel*H + y)*W + x
    assign addr_full = AW'(s1_rowbase_reg) * AW'(w_c) + AW'(s1_x_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            addr_out_reg <= s1_pad_reg ? '0 : ADDR_W'(addr_full);
            pad_out_reg  <= s1_pad_reg;
            last_out_reg <= s1_last_reg;
            geo_out_reg  <= s1_geo_reg;
            kc_out_reg   <= s1_kc_reg;
            kr_out_reg   <= s1_kr_reg;
            ch_out_reg   <= s1_ch_reg;
            pc_out_reg   <= s1_pc_reg;
            pr_out_reg   <= s1_pr_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign source_address = addr_out_reg;
    assign is_padding     = pad_out_reg;
    assign kernel_col     = kc_out_reg;
    assign kernel_row     = kr_out_reg;
    assign channel_index  = ch_out_reg;
    assign patch_col      = pc_out_reg;
    assign patch_row      = pr_out_reg;
    assign last           = last_out_reg;
    assign geometry_error = geo_out_reg;

endmodule

### hdl/im2col_ctrl.sv
// ----------------------------------------------------------------------------
// im2col_ctrl
// Controller: after reset and every register write, runs the patch count
// setup for the x and then the y axis, then lets requests stream.
// ----------------------------------------------------------------------------
module im2col_ctrl
    import im2col_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  im2col_status_t status,
    output im2col_cmd_t    cmd
);

    localparam logic [2:0] ST_DIV_X  = 3'd0;
    localparam logic [2:0] ST_WAIT_X = 3'd1;
    localparam logic [2:0] ST_DIV_Y  = 3'd2;
    localparam logic [2:0] ST_WAIT_Y = 3'd3;
    localparam logic [2:0] ST_RUN    = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd.div_start = 1'b0;
        cmd.div_sel   = AXIS_X;
        cmd.load_npx  = 1'b0;
        cmd.load_npy  = 1'b0;
        cmd.run       = 1'b0;
        unique case (state_reg)
            ST_DIV_X:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_WAIT_X;
            end
            ST_WAIT_X:
            begin
                if (status.div_done)
                begin
                    cmd.load_npx = 1'b1;
                    state_next   = ST_DIV_Y;
                end
            end
            ST_DIV_Y:
            begin
                cmd.div_sel   = AXIS_Y;
                cmd.div_start = 1'b1;
                state_next    = ST_WAIT_Y;
            end
            ST_WAIT_Y:
            begin
                cmd.div_sel = AXIS_Y;
                if (status.div_done)
                begin
                    cmd.load_npy = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.run = 1'b1;
            end
            default:
            begin
                state_next = ST_DIV_X;
            end
        endcase
        if (status.cfg_hit)
        begin
            state_next = ST_DIV_X;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_DIV_X;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/im2col_patch_address_generator.sv
// ----------------------------------------------------------------------------
// im2col_patch_address_generator
// Streams im2col element addresses of a padded, strided convolution.
// ----------------------------------------------------------------------------
// Each accepted request yields one element of the stacked matrix: its linear
// source address in the channel-major image, a padding flag, its coordinates
// and a last flag. Once set up, the block takes one request per clock while
// the output does not stall and delivers each result through the stage-1 and
// output registers; a stall on the output holds the whole two-stage address
// pipeline. After reset and after every register write, a setup pass, during
// which in_stall stays high, works out the patch counts of both axes with a
// bit-serial divider, one quotient bit per clock. Register writes are taken
// at any time.
// ----------------------------------------------------------------------------
module im2col_patch_address_generator
    import im2col_pkg::*;
#(
    parameter int MAX_DIM      = 1024,
    parameter int MAX_CHANNELS = 1024,
    parameter int MAX_WINDOW   = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   restart,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [ADDR_W-1:0]      source_address,
    output logic                   is_padding,
    output logic [KOFF_W-1:0]      kernel_col,
    output logic [KOFF_W-1:0]      kernel_row,
    output logic [IDX_W-1:0]       channel_index,
    output logic [IDX_W-1:0]       patch_col,
    output logic [IDX_W-1:0]       patch_row,
    output logic                   last,
    output logic                   geometry_error
);

    im2col_cmd_t    cmd;
    im2col_status_t status;

    im2col_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    im2col_dp #(
        .MAX_DIM      (MAX_DIM),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_WINDOW   (MAX_WINDOW)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .restart        (restart),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .source_address (source_address),
        .is_padding     (is_padding),
        .kernel_col     (kernel_col),
        .kernel_row     (kernel_row),
        .channel_index  (channel_index),
        .patch_col      (patch_col),
        .patch_row      (patch_row),
        .last           (last),
        .geometry_error (geometry_error)
    );

endmodule
